/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CHK_LATER2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);
`else
`define CHK_SAME(lbl, ante, cons, msg)
`define CHK_LATER2(lbl, ante, cons, msg)
`endif

`endif

/* sv/lruc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared widths, result codes, controller states and control structs.
// ----------------------------------------------------------------------------
package lruc_pkg;

  localparam int ID_W    = 32;
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = 5;

  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_FILL  = 2'd1,
    ST_EVICT = 2'd2,
    ST_INV   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_COMMIT
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic id_zero;
    logic scan_end;
  } sts_t;

endpackage

/* sv/lru_id_cache_lookup.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// lru_id_cache_lookup
// Fully associative buffer id cache with least-recently-used replacement.
//
//   channel  handshake          payload
//   input    start, busy        in_buffer_id
//   result   out_valid strobe   out_status, out_slot, out_evicted_id
//
// A nonzero id passes accept, a scan of every slot, a drain of the last
// read and a commit of the update before the next accept: the tag and
// stamp RAMs have one read port, so the scan reads one slot a cycle.
// An id of zero goes from accept straight to commit. The result strobe is
// high for one cycle, during which the next word may already be accepted.
// Reset clears valid flags, occupancy and the stamp; RAM contents are masked
// by the valid flags, so no clearing pass runs. The receiver cannot stall.
// ----------------------------------------------------------------------------
module lru_id_cache_lookup
  import lruc_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [ID_W-1:0]   in_buffer_id,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [SLOT_W-1:0] out_slot,
  output logic [ID_W-1:0]   out_evicted_id
);

  cmd_t cmd;
  sts_t sts;

  lruc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  lruc_dp #(.SLOTS(SLOTS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_buffer_id   (in_buffer_id),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_evicted_id (out_evicted_id)
  );

  `CHK_SAME(a_strobe_idle, out_valid, !busy, "result strobe while busy")
  `CHK_LATER2(a_zero_id, start && !busy && in_buffer_id == '0,
    out_valid && out_status == ST_INV, "zero id not reported as invalid")
  `CHK_SAME(a_evict_only, out_valid && out_status != ST_EVICT,
    out_evicted_id == '0, "evicted id set without eviction")
  `CHK_SAME(a_inv_slot, out_valid && out_status == ST_INV,
    out_slot == '0, "invalid id reported a slot")

endmodule

/* sv/lruc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lruc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/lruc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruc_ctrl
// Sequencer: accept, scan every slot (skipped for an id of zero), drain the last read, commit the result.
// ----------------------------------------------------------------------------
module lruc_ctrl
  import lruc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = sts.id_zero ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST:   state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      S_SCAN:   cmd.scan   = 1'b1;
      S_LAST:   cmd        = '0;
      S_COMMIT: cmd.commit = 1'b1;
      default:  cmd        = '0;
    endcase
  end

endmodule

/* sv/lruc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruc_dp
// Tag and stamp RAMs, valid flags, scan trackers and the result register.
// ----------------------------------------------------------------------------
module lruc_dp
  import lruc_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [ID_W-1:0]   in_buffer_id,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [SLOT_W-1:0] out_slot,
  output logic [ID_W-1:0]   out_evicted_id
);

  localparam int IW    = $clog2(SLOTS);
  localparam int OCC_W = $clog2(SLOTS + 1);

  logic [ID_W-1:0]    id_r;
  logic               inv_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [OCC_W-1:0]   occ_r;
  logic [SLOTS-1:0]   valid_r;

  logic [IW-1:0]      scan_idx_r;
  logic               cmp_vld_r;
  logic [IW-1:0]      cmp_idx_r;

  logic               hit_r;
  logic [IW-1:0]      hit_idx_r;
  logic               free_fnd_r;
  logic [IW-1:0]      free_idx_r;
  logic [STAMP_W-1:0] min_stamp_r;
  logic [IW-1:0]      min_idx_r;
  logic [ID_W-1:0]    min_tag_r;

  logic [ID_W-1:0]    tag_rd;
  logic [STAMP_W-1:0] stamp_rd;

  logic               we_tag, we_stamp;
  logic [IW-1:0]      waddr;
  logic               full;
  logic               valid_here;
  status_t            status_sel;
  logic [IW-1:0]      slot_sel;
  logic [ID_W-1:0]    ev_sel;
  logic [IW+SLOT_W-1:0] slot_ext;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [ID_W-1:0]    out_ev_r;

  lruc_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_tag_ram (
    .clk   (clk),
    .we    (we_tag),
    .waddr (waddr),
    .wdata (id_r),
    .re    (cmd.scan),
    .raddr (scan_idx_r),
    .rdata (tag_rd)
  );

  lruc_ram #(.WIDTH(STAMP_W), .DEPTH(SLOTS)) u_stamp_ram (
    .clk   (clk),
    .we    (we_stamp),
    .waddr (waddr),
    .wdata (stamp_r),
    .re    (cmd.scan),
    .raddr (scan_idx_r),
    .rdata (stamp_rd)
  );

  assign sts.id_zero  = (in_buffer_id == '0);
  assign sts.scan_end = (scan_idx_r == IW'(SLOTS - 1));
  assign full         = (occ_r == OCC_W'(SLOTS));
  assign valid_here   = valid_r[cmp_idx_r];

  always_comb begin
    we_tag     = 1'b0;
    we_stamp   = 1'b0;
    waddr      = '0;
    status_sel = ST_INV;
    slot_sel   = '0;
    ev_sel     = '0;
    if (inv_r) begin
      status_sel = ST_INV;
    end else if (hit_r) begin
      status_sel = ST_HIT;
      slot_sel   = hit_idx_r;
      waddr      = hit_idx_r;
      we_stamp   = cmd.commit;
    end else if (!full) begin
      status_sel = ST_FILL;
      slot_sel   = free_idx_r;
      waddr      = free_idx_r;
      we_tag     = cmd.commit;
      we_stamp   = cmd.commit;
    end else begin
      status_sel = ST_EVICT;
      slot_sel   = min_idx_r;
      waddr      = min_idx_r;
      ev_sel     = min_tag_r;
      we_tag     = cmd.commit;
      we_stamp   = cmd.commit;
    end
    slot_ext = {{SLOT_W{1'b0}}, slot_sel};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r       <= 1'b0;
      stamp_r     <= '0;
      occ_r       <= '0;
      valid_r     <= '0;
      scan_idx_r  <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_fnd_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r   <= cmd.scan;
      out_valid_r <= cmd.commit;
      if (cmd.accept) begin
        inv_r      <= sts.id_zero;
        scan_idx_r <= '0;
        hit_r      <= 1'b0;
        free_fnd_r <= 1'b0;
        if (!sts.id_zero) begin
          stamp_r <= stamp_r + 1'b1;
        end
      end
      if (cmd.scan) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (cmp_vld_r) begin
        if (valid_here && tag_rd == id_r && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (!valid_here && !free_fnd_r) begin
          free_fnd_r <= 1'b1;
        end
      end
      if (cmd.commit && !inv_r && !hit_r && !full) begin
        valid_r[free_idx_r] <= 1'b1;
        occ_r               <= occ_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      id_r <= in_buffer_id;
    end
    if (cmp_vld_r) begin
      if (valid_here && tag_rd == id_r && !hit_r) begin
        hit_idx_r <= cmp_idx_r;
      end
      if (!valid_here && !free_fnd_r) begin
        free_idx_r <= cmp_idx_r;
      end
      if (cmp_idx_r == '0 || stamp_rd < min_stamp_r) begin
        min_stamp_r <= stamp_rd;
        min_idx_r   <= cmp_idx_r;
        min_tag_r   <= tag_rd;
      end
    end
    cmp_idx_r <= scan_idx_r;
    if (cmd.commit) begin
      out_status_r <= status_sel;
      out_slot_r   <= slot_ext[SLOT_W-1:0];
      out_ev_r     <= ev_sel;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_evicted_id = out_ev_r;

endmodule
